/* hdl/tspg_pkg.sv */
package tspg_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int AXES        = 3;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    localparam logic [15:0] INTERVAL_RESET = 16'd500;
    localparam logic [15:0] INTERVAL_MIN   = 16'd150;
    localparam logic [15:0] INTERVAL_STEP  = 16'd10;
    localparam logic [15:0] WAIT_TRIM      = 16'd5;
    localparam logic [15:0] PULSE_TICKS    = 16'd2;
    localparam logic [15:0] TARGET_RESET   = 16'd1000;
    localparam logic [2:0]  INVERT_RESET   = 3'd0;
    localparam logic [20:0] LAYOUT_RESET   = 21'd1754760;
    localparam logic [7:0]  IMAGE_RESET    = 8'h01;

    localparam logic MODE_LOAD = 1'b1;

    localparam logic [1:0] CFG_TARGET = 2'd0;
    localparam logic [1:0] CFG_INVERT = 2'd1;
    localparam logic [1:0] CFG_LAYOUT = 2'd2;

    localparam int SLOT_DISABLE = 0;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PULSE = 2'd1,
        PH_WAIT  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [15:0] target;
        logic [2:0]  invert;
        logic [20:0] layout;
    } t_cfg;

    typedef struct packed {
        logic        mode;
        logic [1:0]  axis;
        logic [15:0] step_count;
        logic        direction;
    } t_item;

    typedef struct packed {
        logic [7:0] image;
        logic       changed;
        logic       busy;
    } t_result;

endpackage

/* hdl/tspg_core.sv */
module tspg_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  tspg_pkg::t_item  i_item,
    input  tspg_pkg::t_cfg   i_cfg,
    output tspg_pkg::t_result o_result
);

    tspg_pkg::t_count r_pend [tspg_pkg::AXES];
    tspg_pkg::t_count n_pend [tspg_pkg::AXES];
    logic [tspg_pkg::AXES-1:0] r_dir, n_dir;
    logic [tspg_pkg::AXES-1:0] r_pulsed, n_pulsed;
    logic [15:0]      r_interval, n_interval;
    logic [15:0]      r_timer, n_timer;
    tspg_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_image, n_image;
    logic [7:0]       r_last_image;

    logic             start;
    logic             any_pend;
    logic [15:0]      tgt;

    function automatic logic [2:0] f_pos(input logic [20:0] layout, input int slot);
        f_pos = layout[3*slot +: 3];
    endfunction

    function automatic logic [7:0] f_put(input logic [7:0] img, input logic [2:0] pos,
                                         input logic v);
        logic [7:0] res;
        res      = img;
        res[pos] = v;
        f_put    = res;
    endfunction

    always_comb begin
        any_pend = 1'b0;
        for (int a = 0; a < tspg_pkg::AXES; a++) begin
            if (r_pend[a] != '0) any_pend = 1'b1;
        end
        tgt = (i_cfg.target < tspg_pkg::INTERVAL_MIN) ? tspg_pkg::INTERVAL_MIN : i_cfg.target;
    end

    always_comb begin
        n_pend     = r_pend;
        n_dir      = r_dir;
        n_pulsed   = r_pulsed;
        n_interval = r_interval;
        n_timer    = r_timer;
        n_phase    = r_phase;
        n_image    = r_image;
        start      = 1'b0;
        if (i_item.mode == tspg_pkg::MODE_LOAD) begin
            if (i_item.axis < 2'(tspg_pkg::AXES)) begin
                n_pend[i_item.axis] = tspg_pkg::t_count'(i_item.step_count);
                n_dir[i_item.axis]  = i_item.direction;
            end
        end else begin
            case (r_phase)
                tspg_pkg::PH_PULSE: begin
                    if (r_timer > 16'd1) begin
                        n_timer = r_timer - 16'd1;
                    end else begin
                        for (int a = 0; a < tspg_pkg::AXES; a++) begin
                            if (r_pulsed[a]) begin
                                n_image = f_put(n_image, f_pos(i_cfg.layout, 1 + 2*a), 1'b0);
                                if (r_pend[a] != '0) n_pend[a] = r_pend[a] - 1'b1;
                            end
                        end
                        n_pulsed = '0;
                        if (r_interval > tspg_pkg::WAIT_TRIM) begin
                            n_phase = tspg_pkg::PH_WAIT;
                            n_timer = r_interval - tspg_pkg::WAIT_TRIM;
                        end else begin
                            n_phase = tspg_pkg::PH_IDLE;
                            n_timer = '0;
                        end
                    end
                end
                tspg_pkg::PH_WAIT: begin
                    if (r_timer > 16'd1) begin
                        n_timer = r_timer - 16'd1;
                    end else begin
                        n_timer = '0;
                        start   = 1'b1;
                    end
                end
                default: start = 1'b1;
            endcase

            if (start) begin
                n_phase = tspg_pkg::PH_IDLE;
                if (!any_pend) begin
                    n_image = '0;
                    n_image[f_pos(i_cfg.layout, tspg_pkg::SLOT_DISABLE)] = 1'b1;
                    n_interval = tspg_pkg::INTERVAL_RESET;
                end else begin
                    // later writes win where layout positions overlap
                    n_image = f_put(n_image, f_pos(i_cfg.layout, tspg_pkg::SLOT_DISABLE), 1'b0);
                    for (int a = 0; a < tspg_pkg::AXES; a++) begin
                        n_image = f_put(n_image, f_pos(i_cfg.layout, 2 + 2*a),
                                        r_dir[a] ^ i_cfg.invert[a]);
                    end
                    if (r_interval > tgt) begin
                        n_interval = ({1'b0, r_interval} >= ({1'b0, tgt} + 17'(tspg_pkg::INTERVAL_STEP)))
                                   ? r_interval - tspg_pkg::INTERVAL_STEP : tgt;
                    end else if (r_interval < tgt) begin
                        n_interval = (({1'b0, r_interval} + 17'(tspg_pkg::INTERVAL_STEP)) <= {1'b0, tgt})
                                   ? r_interval + tspg_pkg::INTERVAL_STEP : tgt;
                    end
                    n_pulsed = '0;
                    for (int a = 0; a < tspg_pkg::AXES; a++) begin
                        if (r_pend[a] != '0) begin
                            n_pulsed[a] = 1'b1;
                            n_image = f_put(n_image, f_pos(i_cfg.layout, 1 + 2*a), 1'b1);
                        end
                    end
                    n_phase = tspg_pkg::PH_PULSE;
                    n_timer = tspg_pkg::PULSE_TICKS;
                end
            end
        end
    end

    always_comb begin
        o_result.image   = n_image;
        o_result.changed = (n_image != r_last_image);
        o_result.busy    = (n_phase == tspg_pkg::PH_PULSE) || (n_phase == tspg_pkg::PH_WAIT);
        for (int a = 0; a < tspg_pkg::AXES; a++) begin
            if (n_pend[a] != '0) o_result.busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < tspg_pkg::AXES; a++) r_pend[a] <= '0;
            r_dir        <= '0;
            r_pulsed     <= '0;
            r_interval   <= tspg_pkg::INTERVAL_RESET;
            r_timer      <= '0;
            r_phase      <= tspg_pkg::PH_IDLE;
            r_image      <= tspg_pkg::IMAGE_RESET;
            r_last_image <= tspg_pkg::IMAGE_RESET;
        end else if (i_adv) begin
            r_pend       <= n_pend;
            r_dir        <= n_dir;
            r_pulsed     <= n_pulsed;
            r_interval   <= n_interval;
            r_timer      <= n_timer;
            r_phase      <= n_phase;
            r_image      <= n_image;
            r_last_image <= n_image;
        end
    end

    a_pulse_has_axes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tspg_pkg::PH_PULSE) |-> (r_pulsed != '0))
        else $error("pulse phase with no pulsed axis");

    a_pulse_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tspg_pkg::PH_PULSE) |-> (r_timer == 16'd1 || r_timer == 16'd2))
        else $error("pulse timer out of range");

    a_interval_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_interval >= tspg_pkg::INTERVAL_MIN)
        else $error("step interval below floor");

    a_pulsed_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tspg_pkg::PH_WAIT) |-> (r_pulsed == '0))
        else $error("pulsed axes left set in wait");

endmodule

/* hdl/three_axis_step_pulse_generator_unit.sv */
// An accepted request sits in the input register; its result goes to the result register.
// Throughput: one request per cycle while the output is not stalled; the step state updates
// between the input register and the result register in a single pass.
// Reset (i_rst_n low, synchronous): counts and directions cleared, interval 500 us,
// phase idle, image disable-only, config back to its defaults, both stages empty.
module three_axis_step_pulse_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [1:0]  i_axis,
    input  logic [15:0] i_step_count,
    input  logic        i_direction,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_driver_image,
    output logic        o_image_changed,
    output logic        o_busy_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [20:0] i_cfg_data
);

    tspg_pkg::t_cfg    r_cfg;
    tspg_pkg::t_item   r_item;
    logic              r_in_valid;
    tspg_pkg::t_result r_result;
    logic              r_out_valid;
    tspg_pkg::t_result result;
    logic              adv;

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target <= tspg_pkg::TARGET_RESET;
            r_cfg.invert <= tspg_pkg::INVERT_RESET;
            r_cfg.layout <= tspg_pkg::LAYOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tspg_pkg::CFG_TARGET: r_cfg.target <= i_cfg_data[15:0];
                tspg_pkg::CFG_INVERT: r_cfg.invert <= i_cfg_data[2:0];
                tspg_pkg::CFG_LAYOUT: r_cfg.layout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.mode       <= i_mode;
            r_item.axis       <= i_axis;
            r_item.step_count <= i_step_count;
            r_item.direction  <= i_direction;
        end
    end

    tspg_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) r_result <= result;
    end

    assign o_out_valid     = r_out_valid;
    assign o_driver_image  = r_result.image;
    assign o_image_changed = r_result.changed;
    assign o_busy_res      = r_result.busy;

endmodule
